// File: rtl/core/ffha_pkg.sv
package ffha_pkg;

  // Arena geometry
  localparam int unsigned HEAP_BYTES = 32768;
  localparam int unsigned GRAN_BYTES = 8;
  localparam int unsigned HDR_BYTES  = 16;
  localparam int unsigned MIN_SPLIT  = HDR_BYTES + GRAN_BYTES;
  localparam int unsigned GRANULES   = HEAP_BYTES / GRAN_BYTES;
  localparam int unsigned GA_W       = $clog2(GRANULES);
  localparam int unsigned GRAN_LSB   = $clog2(GRAN_BYTES);
  localparam int unsigned OFS_W      = $clog2(HEAP_BYTES);
  localparam int unsigned SIZE_W     = OFS_W + 1;

  // Working width for offset sums and size compares (covers the largest arena)
  localparam int unsigned XW = 24;

  // Word field widths
  localparam int unsigned REQ_W    = 16;
  localparam int unsigned ADDR_W   = 15;
  localparam int unsigned STATUS_W = 3;

  // Opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADHDR = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NULL   = 3'd4;

  // Constants in working width
  localparam logic [XW-1:0] HEAP_X  = XW'(HEAP_BYTES);
  localparam logic [XW-1:0] HDR_X   = XW'(HDR_BYTES);
  localparam logic [XW-1:0] GRAN_X  = XW'(GRAN_BYTES);
  localparam logic [XW-1:0] SPLIT_X = XW'(MIN_SPLIT);

  // One header store entry
  typedef struct packed {
    logic              valid;
    logic              free;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  localparam int unsigned HDR_W = $bits(hdr_t);

  // Entry 0 after reset: one free block spanning the arena
  localparam hdr_t HDR_INIT = '{valid: 1'b1, free: 1'b1,
                                size: SIZE_W'(HEAP_BYTES - HDR_BYTES)};

  // Header store access from the controller
  typedef struct packed {
    logic            we;
    logic [GA_W-1:0] waddr;
    hdr_t            wdata;
    logic            re;
    logic [GA_W-1:0] raddr;
  } mem_req_t;

  // Finished result handed to the output register
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
  } res_t;

endpackage

// File: rtl/core/ffha_ram.sv
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/ffha_ctrl.sv
module ffha_ctrl import ffha_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [REQ_W-1:0]  in_request_size,
  input  logic [ADDR_W-1:0] in_free_addr,
  output mem_req_t          mem_req,
  input  hdr_t              mem_rdata,
  output res_t              res,
  input  logic              res_take
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ACHK = 3'd2;
  localparam logic [2:0] S_FHDR = 3'd3;
  localparam logic [2:0] S_FNXT = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [GA_W-1:0]     clr_r, clr_nxt;
  logic                op_r, op_nxt;
  logic [XW-1:0]       need_r, need_nxt;
  logic [OFS_W-1:0]    h_r, h_nxt;
  logic [OFS_W-1:0]    end_r, end_nxt;
  logic [SIZE_W-1:0]   acc_r, acc_nxt;
  logic [GA_W-1:0]     pend_addr_r, pend_addr_nxt;
  hdr_t                pend_data_r, pend_data_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;

  logic [XW-1:0] hx, bsz_x, walk_x, tail_x, tail_size_x, user_x;
  logic [XW-1:0] acc_sum_x, end_sum_x;
  logic [XW-1:0] need_raw_x, need_in_x, fa_x, fh_x;
  logic          fit, split, free_bad;

  // Datapath for the header just read
  always_comb begin
    hx          = XW'(h_r);
    bsz_x       = XW'(mem_rdata.size);
    walk_x      = hx + HDR_X + bsz_x;
    fit         = mem_rdata.free && (bsz_x >= need_r);
    split       = bsz_x >= (need_r + SPLIT_X);
    tail_x      = hx + HDR_X + need_r;
    tail_size_x = bsz_x - need_r - HDR_X;
    user_x      = hx + HDR_X;
    acc_sum_x   = XW'(acc_r) + HDR_X + bsz_x;
    end_sum_x   = XW'(end_r) + HDR_X + bsz_x;
  end

  // Request decode: round the size up, check the free address
  always_comb begin
    need_raw_x = XW'(in_request_size) + (GRAN_X - XW'(1));
    need_in_x  = {need_raw_x[XW-1:GRAN_LSB], {GRAN_LSB{1'b0}}};
    fa_x       = XW'(in_free_addr);
    fh_x       = fa_x - HDR_X;
    free_bad   = (fa_x < HDR_X) || (in_free_addr[GRAN_LSB-1:0] != '0) ||
                 (fh_x >= HEAP_X);
  end

  assign in_stall = (state_r != S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    need_nxt       = need_r;
    h_nxt          = h_r;
    end_nxt        = end_r;
    acc_nxt        = acc_r;
    pend_addr_nxt  = pend_addr_r;
    pend_data_nxt  = pend_data_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    mem_req        = '0;
    res.valid      = 1'b0;
    res.status     = res_status_r;
    res.addr       = res_addr_r;

    case (state_r)
      // Sweep the store once after reset
      S_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = (clr_r == '0) ? HDR_INIT : '0;
        clr_nxt       = clr_r + GA_W'(1);
        if (clr_r == GA_W'(GRANULES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a word and start its walk
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_opcode;
          res_addr_nxt = '0;
          if (in_opcode == OP_ALLOC) begin
            if (in_request_size == '0) begin
              res_status_nxt = ST_ZERO;
              state_nxt      = S_RES;
            end else begin
              need_nxt      = need_in_x;
              h_nxt         = '0;
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
              state_nxt     = S_ACHK;
            end
          end else begin
            if (in_free_addr == '0) begin
              res_status_nxt = ST_NULL;
              state_nxt      = S_RES;
            end else if (free_bad) begin
              res_status_nxt = ST_BADHDR;
              state_nxt      = S_RES;
            end else begin
              h_nxt         = fh_x[OFS_W-1:0];
              mem_req.re    = 1'b1;
              mem_req.raddr = fh_x[GRAN_LSB +: GA_W];
              state_nxt     = S_FHDR;
            end
          end
        end
      end

      // Allocate: check one block, take it or advance to the next
      S_ACHK: begin
        if (!mem_rdata.valid) begin
          res_status_nxt = ST_NOFIT;
          state_nxt      = S_RES;
        end else if (fit) begin
          if (split) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = tail_x[GRAN_LSB +: GA_W];
            mem_req.wdata = {1'b1, 1'b1, tail_size_x[SIZE_W-1:0]};
            pend_data_nxt = {1'b1, 1'b0, need_r[SIZE_W-1:0]};
          end else begin
            pend_data_nxt = {1'b1, 1'b0, mem_rdata.size};
          end
          pend_addr_nxt  = hx[GRAN_LSB +: GA_W];
          res_status_nxt = ST_OK;
          res_addr_nxt   = user_x[ADDR_W-1:0];
          state_nxt      = S_WB;
        end else if (walk_x >= HEAP_X) begin
          res_status_nxt = ST_NOFIT;
          state_nxt      = S_RES;
        end else begin
          h_nxt         = walk_x[OFS_W-1:0];
          mem_req.re    = 1'b1;
          mem_req.raddr = walk_x[GRAN_LSB +: GA_W];
        end
      end

      // Free: validate the header, then look at the block after it
      S_FHDR: begin
        if (!mem_rdata.valid) begin
          res_status_nxt = ST_BADHDR;
          state_nxt      = S_RES;
        end else begin
          pend_addr_nxt  = hx[GRAN_LSB +: GA_W];
          acc_nxt        = mem_rdata.size;
          res_status_nxt = ST_OK;
          if (walk_x >= HEAP_X) begin
            pend_data_nxt = {1'b1, 1'b1, mem_rdata.size};
            state_nxt     = S_WB;
          end else begin
            end_nxt       = walk_x[OFS_W-1:0];
            mem_req.re    = 1'b1;
            mem_req.raddr = walk_x[GRAN_LSB +: GA_W];
            state_nxt     = S_FNXT;
          end
        end
      end

      // Free: absorb a following free block and drop its header
      S_FNXT: begin
        if (mem_rdata.valid && mem_rdata.free) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = end_r[GRAN_LSB +: GA_W];
          mem_req.wdata = '0;
          acc_nxt       = acc_sum_x[SIZE_W-1:0];
          if (end_sum_x >= HEAP_X) begin
            pend_data_nxt = {1'b1, 1'b1, acc_sum_x[SIZE_W-1:0]};
            state_nxt     = S_WB;
          end else begin
            end_nxt       = end_sum_x[OFS_W-1:0];
            mem_req.re    = 1'b1;
            mem_req.raddr = end_sum_x[GRAN_LSB +: GA_W];
          end
        end else begin
          pend_data_nxt = {1'b1, 1'b1, acc_r};
          state_nxt     = S_WB;
        end
      end

      // Write back the owning header
      S_WB: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pend_addr_r;
        mem_req.wdata = pend_data_r;
        state_nxt     = S_RES;
      end

      // Hold the result until the output register takes it
      S_RES: begin
        res.valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Walk and result registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    need_r       <= need_nxt;
    h_r          <= h_nxt;
    end_r        <= end_nxt;
    acc_r        <= acc_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_data_r  <= pend_data_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
  end

  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("header store read and write hit the same entry");

  a_aligned_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACHK || state_r == S_FHDR) |-> (h_r[GRAN_LSB-1:0] == '0))
    else $error("header offset not granule aligned");

  a_merge_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FNXT) |-> (end_r > h_r))
    else $error("merge pointer not beyond the freed header");

  a_alloc_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && op_r == OP_ALLOC && res_status_r == ST_OK) |->
    (res_addr_r >= ADDR_W'(HDR_BYTES)))
    else $error("allocated offset lies inside a header");

endmodule

// File: rtl/core/first_fit_heap_allocator.sv
// First-fit heap allocator over a 32 KiB arena with 16-byte block headers
// held in a 4096-entry header store (one entry per 8-byte granule). After
// reset the block sweeps the header store and takes no word meanwhile. An
// allocate walks the block chain from offset 0, one header per cycle
// through the store's single registered read port. A free checks its
// header, then merges each following free block into it until a used block
// or the arena end. Zero-size allocates, null frees and malformed free
// addresses finish without reading the header store, and a free whose header
// granule holds no valid header is refused. One word is worked on at a
// time; a finished result sits in the output register while the next word
// is taken.
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_opcode,
  input  logic [REQ_W-1:0]    in_request_size,
  input  logic [ADDR_W-1:0]   in_free_addr,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [ADDR_W-1:0]   out_addr
);

  mem_req_t            mem_req;
  hdr_t                mem_rdata;
  res_t                res;
  logic                res_take;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;

  ffha_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_request_size (in_request_size),
    .in_free_addr    (in_free_addr),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata),
    .res             (res),
    .res_take        (res_take)
  );

  ffha_ram #(
    .WIDTH (HDR_W),
    .DEPTH (GRANULES)
  ) u_hdr_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Load the output register when it is empty or being drained
  assign res_take = res.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_status_r <= res.status;
      out_addr_r   <= res.addr;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_addr   = out_addr_r;

endmodule

// File: tb/sv/tb_first_fit_heap_allocator.sv
module tb_first_fit_heap_allocator import ffha_pkg::*; ();

  localparam int N_RANDOM    = 1425;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_TU    = 20_000_000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
  } alloc_res_t;

  // Shadow of the header store plus the queue of replies still owed
  class heap_checker;
    bit          hv[GRANULES];
    bit          hf[GRANULES];
    int unsigned hs[GRANULES];
    alloc_res_t  awaited[$];
    int unsigned errs;
    int unsigned n_checked;
    int unsigned n_placed;
    int unsigned n_status[8];

    function new();
      hv[0] = 1'b1;
      hf[0] = 1'b1;
      hs[0] = HEAP_BYTES - HDR_BYTES;
    endfunction

    // Apply one accepted word to the shadow heap and queue its reply
    function alloc_res_t take_request(logic op, logic [REQ_W-1:0] sz,
                                      logic [ADDR_W-1:0] fa);
      alloc_res_t  r;
      int unsigned need, h, g, t, nx, ng, steps;
      bit          done;
      r = '{status: ST_OK, addr: '0};
      steps = 0;
      done = 1'b0;
      if (op == OP_ALLOC) begin
        if (sz == 0) begin
          r.status = ST_ZERO;
        end else begin
          need = (int'(sz) + GRAN_BYTES - 1) & ~(GRAN_BYTES - 1);
          r.status = ST_NOFIT;
          h = 0;
          // Walk the chain from offset 0; stop at the first fitting free block
          while (!done && h < HEAP_BYTES && steps < GRANULES) begin
            g = h / GRAN_BYTES;
            if (!hv[g]) begin
              done = 1'b1;
            end else if (hf[g] && hs[g] >= need) begin
              if (hs[g] >= need + MIN_SPLIT) begin
                t = (h + HDR_BYTES + need) / GRAN_BYTES;
                if (t < GRANULES) begin
                  hv[t] = 1'b1;
                  hf[t] = 1'b1;
                  hs[t] = hs[g] - need - HDR_BYTES;
                  hs[g] = need;
                end
              end
              hf[g] = 1'b0;
              r = '{status: ST_OK, addr: ADDR_W'(h + HDR_BYTES)};
              done = 1'b1;
            end else begin
              h = h + HDR_BYTES + hs[g];
              steps++;
            end
          end
        end
      end else begin
        if (fa == 0) begin
          r.status = ST_NULL;
        end else if (fa < HDR_BYTES || (fa % GRAN_BYTES) != 0) begin
          r.status = ST_BADHDR;
        end else begin
          h = fa - HDR_BYTES;
          g = h / GRAN_BYTES;
          if (h >= HEAP_BYTES || !hv[g]) begin
            r.status = ST_BADHDR;
          end else begin
            hf[g] = 1'b1;
            // Merge forward while the next block is a valid free one
            while (!done && steps < GRANULES) begin
              nx = h + HDR_BYTES + hs[g];
              if (nx >= HEAP_BYTES) begin
                done = 1'b1;
              end else begin
                ng = nx / GRAN_BYTES;
                if (!hv[ng] || !hf[ng]) begin
                  done = 1'b1;
                end else begin
                  hs[g] = hs[g] + HDR_BYTES + hs[ng];
                  hv[ng] = 1'b0;
                  hf[ng] = 1'b0;
                  hs[ng] = 0;
                  steps++;
                end
              end
            end
          end
        end
      end
      n_status[r.status]++;
      if (op == OP_ALLOC && r.status == ST_OK) n_placed++;
      awaited.push_back(r);
      return r;
    endfunction

    // Compare one reply with the oldest awaited one
    function void check_reply(logic [STATUS_W-1:0] st, logic [ADDR_W-1:0] ad);
      alloc_res_t e;
      n_checked++;
      if (awaited.size() == 0) begin
        errs++;
        if (errs <= 10)
          $display("reply %0d with none awaited: status %0d addr %0d",
                   n_checked, st, ad);
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status || ad !== e.addr) begin
        errs++;
        if (errs <= 10)
          $display("reply %0d: status expected %0d got %0d, addr expected %0d got %0d",
                   n_checked, e.status, st, e.addr, ad);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_opcode;
  logic [REQ_W-1:0]    in_request_size;
  logic [ADDR_W-1:0]   in_free_addr;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_addr;

  heap_checker     sb = new();
  int unsigned     live_q[$];
  int unsigned     freed_q[$];
  int unsigned     words_sent;
  int unsigned     n_directed;
  bit              quiet;
  bit              hold_rx;

  first_fit_heap_allocator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_request_size (in_request_size),
    .in_free_addr    (in_free_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_addr        (out_addr)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one word after an optional gap and hold it until taken
  task automatic send_word(input logic op, input logic [REQ_W-1:0] sz,
                           input logic [ADDR_W-1:0] fa, input int gap);
    alloc_res_t r;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_request_size <= sz;
    in_free_addr    <= fa;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = sb.take_request(op, sz, fa);
    if (op == OP_ALLOC && r.status == ST_OK) live_q.push_back(r.addr);
    words_sent++;
  endtask

  // Drain: drop valid and wait for every owed reply
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // Check replies as they are taken
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_reply(out_status, out_addr);
  end

  // Receiver back-pressure: random stalls, quiet stretches, one long hold
  initial begin : rx_drive
    int n;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Main sequence
  initial begin : stim
    int k, s, j, gap;
    logic [REQ_W-1:0]  sz;
    logic [ADDR_W-1:0] fa;
    quiet   = 1'b0;
    hold_rx = 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= OP_ALLOC;
    in_request_size <= '0;
    in_free_addr    <= '0;
    rst_n           <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero size, null and malformed frees, oversize, double free,
    // forward merge, absorbed header, exact fit, split leaving a minimal tail
    send_word(OP_ALLOC, 16'd0,     15'd0,     gap_len());
    send_word(OP_FREE,  16'hFFFF,  15'd0,     gap_len());
    send_word(OP_ALLOC, 16'd1,     15'h7FFF,  gap_len());
    send_word(OP_ALLOC, 16'd8,     15'd0,     gap_len());
    send_word(OP_ALLOC, 16'hFFFF,  15'd0,     gap_len());
    send_word(OP_ALLOC, 16'd32768, 15'd0,     gap_len());
    send_word(OP_FREE,  16'd0,     15'd3,     gap_len());
    send_word(OP_FREE,  16'd0,     15'd20,    gap_len());
    send_word(OP_FREE,  16'd0,     15'd24,    gap_len());
    send_word(OP_FREE,  16'd0,     15'h7FFF,  gap_len());
    send_word(OP_FREE,  16'd0,     15'd32760, gap_len());
    send_word(OP_FREE,  16'd0,     15'd16,    gap_len());
    send_word(OP_FREE,  16'd0,     15'd16,    gap_len());
    send_word(OP_FREE,  16'd0,     15'd40,    gap_len());
    send_word(OP_FREE,  16'd0,     15'd16,    gap_len());
    send_word(OP_FREE,  16'd0,     15'd40,    gap_len());
    send_word(OP_ALLOC, 16'd32752, 15'd0,     gap_len());
    send_word(OP_ALLOC, 16'd1,     15'd0,     gap_len());
    send_word(OP_FREE,  16'd0,     15'd16,    gap_len());
    send_word(OP_ALLOC, 16'd32728, 15'd0,     gap_len());
    send_word(OP_ALLOC, 16'd8,     15'd0,     gap_len());
    send_word(OP_FREE,  16'd0,     15'd16,    gap_len());
    send_word(OP_FREE,  16'd0,     15'd32760, gap_len());
    send_word(OP_ALLOC, 16'd32729, 15'd0,     gap_len());
    send_word(OP_FREE,  16'd0,     15'd16,    gap_len());
    send_word(OP_ALLOC, 16'd32729, 15'd0,     gap_len());
    send_word(OP_FREE,  16'd0,     15'd16,    gap_len());
    n_directed = words_sent;
    drain_replies();
    live_q.delete();

    // Random: mostly allocate/free of live blocks, some double frees and noise
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = (i >= 300 && i < 420);
      if (i == 700) hold_rx = 1'b1;
      if (i == 1000) drain_replies();
      gap = (quiet || (i >= 700 && i < 760)) ? 0 : gap_len();
      k = $urandom_range(0, 99);
      if (live_q.size() > 48 && k < 50) k = 50;
      if (k >= 50 && k < 88 && live_q.size() == 0) k = 0;
      if (k < 50) begin
        s = $urandom_range(0, 99);
        if (s < 2)       sz = 16'd0;
        else if (s < 70) sz = REQ_W'($urandom_range(1, 256));
        else if (s < 92) sz = REQ_W'($urandom_range(257, 4096));
        else if (s < 98) sz = REQ_W'($urandom_range(4097, 32768));
        else             sz = REQ_W'($urandom_range(32769, 65535));
        send_word(OP_ALLOC, sz, ADDR_W'($urandom), gap);
      end else if (k < 88) begin
        j = $urandom_range(0, live_q.size() - 1);
        fa = ADDR_W'(live_q[j]);
        live_q.delete(j);
        freed_q.push_back(fa);
        if (freed_q.size() > 8) void'(freed_q.pop_front());
        send_word(OP_FREE, REQ_W'($urandom), fa, gap);
      end else if (k < 92 && freed_q.size() > 0) begin
        fa = ADDR_W'(freed_q[$urandom_range(0, freed_q.size() - 1)]);
        send_word(OP_FREE, REQ_W'($urandom), fa, gap);
      end else begin
        case ($urandom_range(0, 3))
          0: fa = '0;
          1: fa = ADDR_W'($urandom);
          2: fa = ADDR_W'($urandom) & ~ADDR_W'(GRAN_BYTES - 1);
          default: fa = ADDR_W'($urandom_range(1, 40));
        endcase
        send_word(OP_FREE, REQ_W'($urandom), fa, gap);
      end
    end

    // Wind down: wait for the last replies, then watch for strays
    drain_replies();
    repeat (20) @(posedge clk);

    $display("%0d words driven (%0d directed), %0d replies checked, %0d mismatches",
             words_sent, n_directed, sb.n_checked, sb.errs);
    $display("allocs placed %0d, no fit %0d, zero size %0d; frees done %0d, bad %0d, null %0d",
             sb.n_placed, sb.n_status[ST_NOFIT], sb.n_status[ST_ZERO],
             sb.n_status[ST_OK] - sb.n_placed, sb.n_status[ST_BADHDR],
             sb.n_status[ST_NULL]);
    if (sb.errs == 0 && sb.awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(LIMIT_TU);
    $display("simulation failed");
    $finish;
  end

endmodule
